### design/bba_pkg.sv
// bba_pkg: shared types and constants of the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

    localparam int CMD_W   = 1;
    localparam int REQ_W   = 12;
    localparam int INDEX_W = 7;
    localparam int LEVEL_W = 3;
    localparam int LVL_W   = 4;
    localparam int HDR_W   = LVL_W + 1;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    typedef struct packed {
        logic             free;
        logic [LVL_W-1:0] level;
    } hdr_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD,
        IDX_SIB,
        IDX_PARENT
    } idx_op_t;

    typedef enum logic [2:0] {
        LVL_HOLD,
        LVL_ZERO,
        LVL_INC,
        LVL_DEC,
        LVL_HDR
    } lvl_op_t;

    typedef enum logic [2:0] {
        ADDR_IDX,
        ADDR_SPLIT_BUD,
        ADDR_BUD,
        ADDR_PARENT,
        ADDR_ZERO
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_TAKE,
        WD_SPLIT,
        WD_FREE_HDR,
        WD_MERGE
    } wd_sel_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_ALLOC_OK,
        RES_FAIL,
        RES_FREE
    } res_op_t;

    typedef struct packed {
        logic      load_in;
        logic      rd_en;
        logic      wr_en;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        idx_op_t   idx_op;
        lvl_op_t   lvl_op;
        res_op_t   res_op;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_free;
        logic eval_stop;
        logic hdr_gt;
        logic hdr_eq;
        logic hdr_free;
        logic take_now;
        logic is_left;
        logic lvl_zero;
        logic merge_stop;
        logic bud_ok;
    } dp_status_t;

endpackage
`default_nettype wire

### design/bba_if.sv
// bba_if: request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [REQ_W-1:0]   request_bytes;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, command, request_bytes, block_index, input ready);
    modport sink   (input valid, command, request_bytes, block_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [INDEX_W-1:0] alloc_index;
    logic [LEVEL_W-1:0] alloc_level;
    logic               region_empty;

    modport source (output valid, ok, alloc_index, alloc_level, region_empty, input ready);
    modport sink   (input valid, ok, alloc_index, alloc_level, region_empty, output ready);
endinterface
`default_nettype wire

### design/bba_ram.sv
// bba_ram: generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### design/bba_ctrl.sv
// bba_ctrl: sequencer for tree walk, split, free and merge
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl import bba_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);
    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_DISPATCH = 16'b0000_0000_0000_0010,
        S_A_EVAL   = 16'b0000_0000_0000_0100,
        S_A_WAIT   = 16'b0000_0000_0000_1000,
        S_A_SPLIT  = 16'b0000_0000_0001_0000,
        S_A_SIB    = 16'b0000_0000_0010_0000,
        S_A_UP     = 16'b0000_0000_0100_0000,
        S_F_RD     = 16'b0000_0000_1000_0000,
        S_F_SET    = 16'b0000_0001_0000_0000,
        S_M_BUD    = 16'b0000_0010_0000_0000,
        S_M_WAIT   = 16'b0000_0100_0000_0000,
        S_R0_RD    = 16'b0000_1000_0000_0000,
        S_R0_WAIT  = 16'b0001_0000_0000_0000,
        S_FIN_OK   = 16'b0010_0000_0000_0000,
        S_FIN_FAIL = 16'b0100_0000_0000_0000,
        S_FIN_FREE = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   fin_load;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        fin_load     = 1'b0;
        cmd          = '0;
        cmd.addr_sel = ADDR_IDX;
        cmd.wd_sel   = WD_TAKE;
        cmd.idx_op   = IDX_HOLD;
        cmd.lvl_op   = LVL_HOLD;
        cmd.res_op   = RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_op  = IDX_LOAD;
                    cmd.lvl_op  = LVL_ZERO;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = status.cmd_free ? S_F_RD : S_A_EVAL;
            end
            S_A_EVAL:
            begin
                if (status.eval_stop)
                begin
                    state_next = S_A_UP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_A_WAIT;
                end
            end
            S_A_WAIT:
            begin
                if (status.hdr_gt)
                begin
                    cmd.lvl_op = LVL_INC;
                    state_next = S_A_EVAL;
                end
                else if (status.hdr_eq && status.hdr_free)
                begin
                    cmd.wr_en = 1'b1;
                    if (status.take_now)
                    begin
                        cmd.wd_sel = WD_TAKE;
                        state_next = S_FIN_OK;
                    end
                    else
                    begin
                        cmd.wd_sel = WD_SPLIT;
                        state_next = S_A_SPLIT;
                    end
                end
                else if (status.hdr_eq)
                begin
                    state_next = S_A_SIB;
                end
                else
                begin
                    state_next = S_A_UP;
                end
            end
            S_A_SPLIT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = ADDR_SPLIT_BUD;
                cmd.wd_sel   = WD_SPLIT;
                cmd.lvl_op   = LVL_INC;
                state_next   = S_A_EVAL;
            end
            S_A_SIB:
            begin
                if (!status.lvl_zero && status.is_left)
                begin
                    cmd.idx_op = IDX_SIB;
                    state_next = S_A_EVAL;
                end
                else
                begin
                    state_next = S_A_UP;
                end
            end
            S_A_UP:
            begin
                if (status.lvl_zero)
                begin
                    state_next = S_FIN_FAIL;
                end
                else
                begin
                    cmd.idx_op = IDX_PARENT;
                    cmd.lvl_op = LVL_DEC;
                    state_next = S_A_SIB;
                end
            end
            S_F_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_F_SET;
            end
            S_F_SET:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = WD_FREE_HDR;
                cmd.lvl_op = LVL_HDR;
                state_next = S_M_BUD;
            end
            S_M_BUD:
            begin
                if (status.merge_stop)
                begin
                    state_next = S_R0_RD;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_BUD;
                    state_next   = S_M_WAIT;
                end
            end
            S_M_WAIT:
            begin
                if (status.bud_ok)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.addr_sel = ADDR_PARENT;
                    cmd.wd_sel   = WD_MERGE;
                    cmd.idx_op   = IDX_PARENT;
                    cmd.lvl_op   = LVL_DEC;
                    state_next   = S_M_BUD;
                end
                else
                begin
                    state_next = S_R0_RD;
                end
            end
            S_R0_RD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_ZERO;
                state_next   = S_R0_WAIT;
            end
            S_R0_WAIT:
            begin
                state_next = S_FIN_FREE;
            end
            S_FIN_OK, S_FIN_FAIL, S_FIN_FREE:
            begin
                if (slot_free)
                begin
                    fin_load   = 1'b1;
                    state_next = S_IDLE;
                    if (state_reg == S_FIN_OK)
                    begin
                        cmd.res_op = RES_ALLOC_OK;
                    end
                    else if (state_reg == S_FIN_FAIL)
                    begin
                        cmd.res_op = RES_FAIL;
                    end
                    else
                    begin
                        cmd.res_op = RES_FREE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || fin_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

### design/bba_dp.sv
// bba_dp: index and level registers, header decode and result registers
`timescale 1ns / 1ps
`default_nettype none
module bba_dp import bba_pkg::*; #(
    parameter int REGION_BYTES = 4096,
    parameter int LEVELS       = 8,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    input  wire logic [CMD_W-1:0]     in_command,
    input  wire logic [REQ_W-1:0]     in_request_bytes,
    input  wire logic [INDEX_W-1:0]   in_block_index,
    output logic                      ok,
    output logic      [INDEX_W-1:0]   alloc_index,
    output logic      [LEVEL_W-1:0]   alloc_level,
    output logic                      region_empty,
    output logic                      mem_rd_en,
    output logic                      mem_wr_en,
    output logic      [LEVELS-2:0]    mem_addr,
    output logic      [HDR_W-1:0]     mem_wdata,
    input  wire logic [HDR_W-1:0]     mem_rdata
);
    localparam int AW = LEVELS - 1;
    localparam int RW = $clog2(REGION_BYTES) + 1;
    localparam int CW = ((RW > REQ_W) ? RW : REQ_W) + 1;
    localparam logic [AW:0]       SPAN_TOP = {1'b1, {AW{1'b0}}};
    localparam logic [LVL_W-1:0]  LVL_MAX  = LVL_W'(LEVELS);
    localparam logic [CW-1:0]     REGION_C = CW'(REGION_BYTES);

    logic [CMD_W-1:0] cmd_reg;
    logic [REQ_W-1:0] size_reg;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [LVL_W-1:0] lvl_p1, lvl_m1;
    logic             root_fresh_reg, root_fresh_next;
    logic             ovr_reg, ovr_next;
    logic             ok_reg, empty_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [AW-1:0]    span_l, span_l1;
    logic [CW-1:0]    need;
    logic             small_l, small_l1;
    hdr_t             hdr, wd;

    assign lvl_p1  = lvl_reg + 1'b1;
    assign lvl_m1  = lvl_reg - 1'b1;
    assign span_l  = AW'(SPAN_TOP >> lvl_reg);
    assign span_l1 = AW'(SPAN_TOP >> lvl_p1);
    assign need    = CW'(size_reg) + CW'(HEADER_BYTES);
    // usable size below request: block bytes less than request plus header
    assign small_l  = (REGION_C >> lvl_reg) < need;
    assign small_l1 = (REGION_C >> lvl_p1) < need;

    // entry zero reads as a free whole-region block until first written
    assign hdr = ovr_reg ? hdr_t'{free: 1'b1, level: '0} : hdr_t'(mem_rdata);

    always_comb
    begin
        status.cmd_free   = (cmd_reg == CMD_FREE);
        status.eval_stop  = (lvl_reg >= LVL_MAX) || small_l;
        status.hdr_gt     = hdr.level > lvl_reg;
        status.hdr_eq     = hdr.level == lvl_reg;
        status.hdr_free   = hdr.free;
        status.take_now   = (lvl_p1 >= LVL_MAX) || small_l1;
        status.is_left    = (idx_reg & span_l) == '0;
        status.lvl_zero   = (lvl_reg == '0);
        status.merge_stop = (lvl_reg == '0) || (lvl_reg >= LVL_MAX);
        status.bud_ok     = (hdr.level == lvl_reg) && hdr.free;
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_IDX:       mem_addr = idx_reg;
            ADDR_SPLIT_BUD: mem_addr = idx_reg ^ span_l1;
            ADDR_BUD:       mem_addr = idx_reg ^ span_l;
            ADDR_PARENT:    mem_addr = idx_reg & ~span_l;
            ADDR_ZERO:      mem_addr = '0;
            default:        mem_addr = idx_reg;
        endcase
        case (cmd.wd_sel)
            WD_TAKE:     wd = hdr_t'{free: 1'b0, level: lvl_reg};
            WD_SPLIT:    wd = hdr_t'{free: 1'b1, level: lvl_p1};
            WD_FREE_HDR: wd = hdr_t'{free: 1'b1, level: hdr.level};
            WD_MERGE:    wd = hdr_t'{free: 1'b1, level: lvl_m1};
            default:     wd = hdr_t'{free: 1'b1, level: lvl_reg};
        endcase
    end

    assign mem_wdata = wd;
    assign mem_rd_en = cmd.rd_en;
    assign mem_wr_en = cmd.wr_en;

    always_comb
    begin
        case (cmd.idx_op)
            IDX_LOAD:   idx_next = (in_command == CMD_FREE) ? AW'(in_block_index) : '0;
            IDX_SIB:    idx_next = idx_reg ^ span_l;
            IDX_PARENT: idx_next = idx_reg & ~span_l;
            default:    idx_next = idx_reg;
        endcase
        case (cmd.lvl_op)
            LVL_ZERO: lvl_next = '0;
            LVL_INC:  lvl_next = lvl_p1;
            LVL_DEC:  lvl_next = lvl_m1;
            LVL_HDR:  lvl_next = hdr.level;
            default:  lvl_next = lvl_reg;
        endcase
    end

    assign root_fresh_next = root_fresh_reg && !(cmd.wr_en && mem_addr == '0);
    assign ovr_next        = cmd.rd_en ? (root_fresh_reg && mem_addr == '0) : ovr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_fresh_reg <= 1'b1;
            ovr_reg        <= 1'b0;
        end
        else
        begin
            root_fresh_reg <= root_fresh_next;
            ovr_reg        <= ovr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lvl_reg <= lvl_next;
        if (cmd.load_in)
        begin
            cmd_reg  <= in_command;
            size_reg <= in_request_bytes;
        end
        case (cmd.res_op)
            RES_ALLOC_OK:
            begin
                ok_reg    <= 1'b1;
                index_reg <= INDEX_W'(idx_reg);
                level_reg <= LEVEL_W'(lvl_reg);
                empty_reg <= 1'b0;
            end
            RES_FAIL:
            begin
                ok_reg    <= 1'b0;
                index_reg <= '0;
                level_reg <= '0;
                empty_reg <= 1'b0;
            end
            RES_FREE:
            begin
                ok_reg    <= 1'b1;
                index_reg <= '0;
                level_reg <= '0;
                empty_reg <= (hdr.level == '0) && hdr.free;
            end
            default:
            begin
            end
        endcase
    end

    assign ok           = ok_reg;
    assign alloc_index  = index_reg;
    assign alloc_level  = level_reg;
    assign region_empty = empty_reg;
endmodule
`default_nettype wire

### design/buddy_block_allocator_core.sv
// buddy_block_allocator_core: top level of the binary buddy allocator
`timescale 1ns / 1ps
`default_nettype none
// Binary buddy allocator over one region of REGION_BYTES, split into at most
// LEVELS levels; blocks are named by their index in units of the smallest
// block. Every request transaction yields exactly one response transaction.
// One request is worked on at a time; the next request is taken as soon as
// the previous response sits in the output register. An allocate walks the
// block tree depth first from the left through the single header memory:
// it reads a node's header, then descends, splits the node, steps sideways
// or steps up; the tree holds 255 nodes at the default sizes. A free marks
// the block free, merges it with its free buddy level by level, then reads
// entry zero to report an empty region. Header memory needs no clearing pass:
// entry zero reads as one free whole-region block from reset.
module buddy_block_allocator_core import bba_pkg::*; #(
    parameter int REGION_BYTES = 4096,
    parameter int LEVELS       = 8,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bba_req_if.sink    req,
    bba_rsp_if.source  rsp
);
    localparam int AW = LEVELS - 1;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic             mem_rd_en, mem_wr_en;
    logic [AW-1:0]    mem_addr;
    logic [HDR_W-1:0] mem_wdata, mem_rdata;

    // sequencer: walk, split, merge and response handshake
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: tree position, header decode, response registers
    bba_dp #(
        .REGION_BYTES (REGION_BYTES),
        .LEVELS       (LEVELS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_command       (req.command),
        .in_request_bytes (req.request_bytes),
        .in_block_index   (req.block_index),
        .ok               (rsp.ok),
        .alloc_index      (rsp.alloc_index),
        .alloc_level      (rsp.alloc_level),
        .region_empty     (rsp.region_empty),
        .mem_rd_en        (mem_rd_en),
        .mem_wr_en        (mem_wr_en),
        .mem_addr         (mem_addr),
        .mem_wdata        (mem_wdata),
        .mem_rdata        (mem_rdata)
    );

    // block headers, one per smallest-block index: free flag and level
    bba_ram #(
        .WIDTH (HDR_W),
        .DEPTH (1 << AW)
    ) u_hdr_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wdata)
    );

    // a taken request keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous transaction still in work");

    // a failed allocation reports no block and no empty region
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.alloc_index == '0 && rsp.alloc_level == '0
                                    && !rsp.region_empty))
        else $error("failed response carries non-zero fields");

    // empty region is only reported on a successful free
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.region_empty) |-> (rsp.ok && rsp.alloc_index == '0))
        else $error("region empty flagged on a non-free response");
endmodule
`default_nettype wire
